### design/skt_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted key table: transaction payload types, action and
// status codes, the cell operation code and the default parameter values.
// Depends on nothing; used by skt_cell, sorted_key_table and the testbench.
package skt_pkg;

    // Default configuration of the table.
    localparam int DEF_CAPACITY = 64;
    localparam int DEF_KEY_BITS = 16;

    // Fixed widths of the transaction fields.
    localparam int ACT_W    = 2;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 3;

    // Action codes of an input transaction.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;

    // Status codes of an output transaction.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LIST      = 3'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd7;

    // Input transaction payload.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key_in;
    } t_in;

    // Output transaction payload.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key_out;
        logic                last;
    } t_out;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_CMP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_ROTATE = 3'd4
    } t_cell_op;

endpackage

### design/skt_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted key chain: holds one key and its compare flags.
// Depends on skt_pkg for the cell operation code.
module skt_cell #(
    parameter int KEY_BITS = skt_pkg::DEF_KEY_BITS,
    parameter int CNT_BITS = 7,
    parameter int IDX      = 0
) (
    input  logic               i_clk,
    input  skt_pkg::t_cell_op  i_op,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [CNT_BITS-1:0] i_count,
    input  logic [KEY_BITS-1:0] i_prev_key,
    input  logic               i_prev_lt,
    input  logic [KEY_BITS-1:0] i_next_key,
    input  logic [KEY_BITS-1:0] i_head_key,
    output logic [KEY_BITS-1:0] o_key,
    output logic               o_lt,
    output logic               o_eq
);

    localparam logic [CNT_BITS-1:0] IDX_C  = CNT_BITS'(IDX);
    localparam logic [CNT_BITS-1:0] IDX_N  = CNT_BITS'(IDX + 1);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_lt, r_eq;
    logic                w_occ;

    // The cell holds a stored key when its place lies below the entry count.
    assign w_occ = (IDX_C < i_count);

    // Compare flags: registered so that the update stage sees short paths.
    always_ff @(posedge i_clk) begin
        if (i_op == skt_pkg::OP_CMP) begin
            r_lt <= w_occ && (r_key < i_key);
            r_eq <= w_occ && (r_key == i_key);
        end
    end

    // Next key: keep, take the new key, or take a neighbour's key.
    always_comb begin
        n_key = r_key;
        case (i_op)
            skt_pkg::OP_INSERT: begin
                if (IDX_C <= i_count && !r_lt) begin
                    n_key = i_prev_lt ? i_key : i_prev_key;
                end
            end
            skt_pkg::OP_DELETE: begin
                if (w_occ && !r_lt) begin
                    n_key = i_next_key;
                end
            end
            skt_pkg::OP_ROTATE: begin
                if (IDX_N < i_count) begin
                    n_key = i_next_key;
                end else if (IDX_N == i_count) begin
                    n_key = i_head_key;
                end
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

### design/sorted_key_table.sv
`timescale 1ns / 1ps
// Sorted key table: a chain of key cells kept in ascending order.
// Insert and delete: compare in every cell (S_CMP), then shift (S_UPD); the result is registered
// in S_UPD once the output is free, and no new item is taken until then (accept, compare, update).
// List: compare and update as above, then one entry per cycle while the output is not stalled.
// Synchronous active-low reset clears the state machine, entry count and output valid;
// the key cells are not cleared and are only read below the entry count.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = skt_pkg::DEF_KEY_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  skt_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output skt_pkg::t_out o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [skt_pkg::ACT_W-1:0] r_act;
    logic [KEY_BITS-1:0]      r_key;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_lidx, n_lidx;
    logic                     r_out_vld;
    skt_pkg::t_out            r_out;

    skt_pkg::t_cell_op        w_op;
    skt_pkg::t_out            w_res;
    logic                     w_emit;
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_hit;
    logic                     w_list_last;
    logic [KEY_BITS-1:0]      w_key [CAPACITY];
    logic [CAPACITY-1:0]      w_lt;
    logic [CAPACITY-1:0]      w_eq;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;

    // Match line: any stored key equal to the operand.
    assign w_hit       = |w_eq;
    assign w_list_last = (r_lidx == r_count - CW'(1));

    // Chain of cells; each reads its neighbours and the head of the chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_prev_key, w_next_key;
        logic                w_prev_lt;
        if (g == 0) begin : g_first
            assign w_prev_key = '0;
            assign w_prev_lt  = 1'b1;
        end else begin : g_mid
            assign w_prev_key = w_key[g-1];
            assign w_prev_lt  = w_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next_key = w_key[g];
        end else begin : g_more
            assign w_next_key = w_key[g+1];
        end
        skt_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_BITS (CW),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (w_op),
            .i_key      (r_key),
            .i_count    (r_count),
            .i_prev_key (w_prev_key),
            .i_prev_lt  (w_prev_lt),
            .i_next_key (w_next_key),
            .i_head_key (w_key[0]),
            .o_key      (w_key[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );
    end

    // Sequencer: decides the cell operation, the result and the next state.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_lidx  = r_lidx;
        w_op    = skt_pkg::OP_HOLD;
        w_emit  = 1'b0;
        w_res.status  = skt_pkg::ST_INSERTED;
        w_res.key_out = skt_pkg::KEY_W'(r_key);
        w_res.last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.action == skt_pkg::ACT_INSERT ||
                        i_in.action == skt_pkg::ACT_DELETE ||
                        i_in.action == skt_pkg::ACT_LIST) begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                w_op    = skt_pkg::OP_CMP;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    w_emit  = 1'b1;
                    case (r_act)
                        skt_pkg::ACT_INSERT: begin
                            if (r_key == '0) begin
                                w_res.status = skt_pkg::ST_BAD_KEY;
                            end else if (w_hit) begin
                                w_res.status = skt_pkg::ST_DUPLICATE;
                            end else if (r_count == CW'(CAPACITY)) begin
                                w_res.status = skt_pkg::ST_FULL;
                            end else begin
                                w_res.status = skt_pkg::ST_INSERTED;
                                w_op         = skt_pkg::OP_INSERT;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        skt_pkg::ACT_DELETE: begin
                            if (r_count == '0) begin
                                w_res.status = skt_pkg::ST_EMPTY;
                            end else if (!w_hit) begin
                                w_res.status = skt_pkg::ST_NOT_FOUND;
                            end else begin
                                w_res.status = skt_pkg::ST_DELETED;
                                w_op         = skt_pkg::OP_DELETE;
                                n_count      = r_count - CW'(1);
                            end
                        end
                        skt_pkg::ACT_LIST: begin
                            if (r_count == '0) begin
                                w_res.status  = skt_pkg::ST_EMPTY;
                                w_res.key_out = '0;
                            end else begin
                                w_emit  = 1'b0;
                                n_lidx  = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            w_emit = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    // Emit the head and rotate the stored keys by one place.
                    w_emit        = 1'b1;
                    w_res.status  = skt_pkg::ST_LIST;
                    w_res.key_out = skt_pkg::KEY_W'(w_key[0]);
                    w_res.last    = w_list_last;
                    w_op          = skt_pkg::OP_ROTATE;
                    n_lidx        = r_lidx + CW'(1);
                    if (w_list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_lidx    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lidx  <= n_lidx;
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Operand and output payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_in.action;
            r_key <= KEY_BITS'(i_in.key_in);
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // The entry count never passes the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A list sweep only runs over a non-empty table.
    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_count != '0))
        else $error("list sweep on empty table");

    // A successful insert grows the table by exactly one entry.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_res.status == skt_pkg::ST_INSERTED)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

    // An accepted insert, delete or list keeps the input stalled while it is in progress.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.action == skt_pkg::ACT_INSERT ||
                      i_in.action == skt_pkg::ACT_DELETE ||
                      i_in.action == skt_pkg::ACT_LIST)) |=> o_in_stall)
        else $error("input taken while busy");

endmodule

### dv/tb_sorted_key_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_table: a queue-fed driver, a clocked monitor
// and a behavioural copy of the sorted table that predicts every output transaction.
// Depends on skt_pkg and the sorted_key_table RTL.
module tb_sorted_key_table;

    localparam int CAPACITY    = skt_pkg::DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 500000;
    localparam int POOL_SIZE   = 40;
    localparam int PHASE_OPS   = 55;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           in_valid = 1'b0;
    skt_pkg::t_in   in_op = '0;
    logic           out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    skt_pkg::t_out  o_out;

    // Pending operations, the predicted replies and the shadow copy of the table.
    skt_pkg::t_in  op_queue[$];
    skt_pkg::t_out table_replies[$];
    logic [15:0]   keys_tbl[CAPACITY];
    int            n_keys = 0;
    logic [15:0]   key_pool[POOL_SIZE];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    sorted_key_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one accepted operation to the shadow table and queue the replies it causes.
    function automatic void apply_table_op(input skt_pkg::t_in op);
        int            pos;
        int            i;
        skt_pkg::t_out r;
        pos = 0;
        r = '0;
        r.key_out = op.key_in;
        r.last = 1'b1;
        while (pos < n_keys && keys_tbl[pos] < op.key_in)
            pos++;
        case (op.action)
            skt_pkg::ACT_INSERT: begin
                if (op.key_in == '0) begin
                    r.status = skt_pkg::ST_BAD_KEY;
                end else if (pos < n_keys && keys_tbl[pos] == op.key_in) begin
                    // A duplicate is reported even when the table is full.
                    r.status = skt_pkg::ST_DUPLICATE;
                end else if (n_keys >= CAPACITY) begin
                    r.status = skt_pkg::ST_FULL;
                end else begin
                    for (i = n_keys; i > pos; i--)
                        keys_tbl[i] = keys_tbl[i-1];
                    keys_tbl[pos] = op.key_in;
                    n_keys++;
                    r.status = skt_pkg::ST_INSERTED;
                end
                table_replies.push_back(r);
            end
            skt_pkg::ACT_DELETE: begin
                if (n_keys == 0) begin
                    r.status = skt_pkg::ST_EMPTY;
                end else if (pos >= n_keys || keys_tbl[pos] != op.key_in) begin
                    r.status = skt_pkg::ST_NOT_FOUND;
                end else begin
                    for (i = pos; i + 1 < n_keys; i++)
                        keys_tbl[i] = keys_tbl[i+1];
                    n_keys--;
                    r.status = skt_pkg::ST_DELETED;
                end
                table_replies.push_back(r);
            end
            skt_pkg::ACT_LIST: begin
                if (n_keys == 0) begin
                    r.status = skt_pkg::ST_EMPTY;
                    r.key_out = '0;
                    table_replies.push_back(r);
                end else begin
                    for (i = 0; i < n_keys; i++) begin
                        r.status = skt_pkg::ST_LIST;
                        r.key_out = keys_tbl[i];
                        r.last = (i == n_keys - 1);
                        table_replies.push_back(r);
                    end
                end
            end
            // The unused action code is ignored by the block and yields nothing.
            default: ;
        endcase
    endfunction

    function automatic skt_pkg::t_in make_op(input logic [skt_pkg::ACT_W-1:0] act,
                                             input logic [15:0] key);
        skt_pkg::t_in op;
        op.action = act;
        op.key_in = key;
        return op;
    endfunction

    // Random operation: keys mostly from a small pool so that hits and duplicates are common.
    function automatic skt_pkg::t_in random_op();
        skt_pkg::t_in op;
        int unsigned  r;
        r = $urandom_range(0, 99);
        if (r < 48)
            op.action = skt_pkg::ACT_INSERT;
        else if (r < 83)
            op.action = skt_pkg::ACT_DELETE;
        else if (r < 95)
            op.action = skt_pkg::ACT_LIST;
        else
            op.action = ~skt_pkg::ACT_INSERT;
        r = $urandom_range(0, 99);
        if (r < 55)
            op.key_in = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 58)
            op.key_in = '0;
        else if (r < 61)
            op.key_in = '1;
        else if (r < 64)
            op.key_in = 16'h0001;
        else
            op.key_in = 16'($urandom_range(0, 16'hFFFF));
        return op;
    endfunction

    // Wait until every queued operation is accepted and every predicted reply has arrived.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (op_queue.size() != 0 || in_valid || table_replies.size() != 0);
    endtask

    // Driver: offers the next pending operation, holding it steady while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                apply_table_op(in_op);
            if (!in_valid || !o_in_stall) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_op <= op_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted output transaction against the oldest prediction.
    always @(posedge i_clk) begin
        skt_pkg::t_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (table_replies.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("Unexpected result: status %0d key %h last %0d",
                             o_out.status, o_out.key_out, o_out.last);
                mismatch_cnt++;
            end else begin
                want = table_replies.pop_front();
                if (o_out.status !== want.status || o_out.key_out !== want.key_out ||
                    o_out.last !== want.last) begin
                    if (mismatch_cnt < 10)
                        $display("Mismatch: expected status %0d key %h last %0d, ",
                                 want.status, want.key_out, want.last,
                                 "got status %0d key %h last %0d",
                                 o_out.status, o_out.key_out, o_out.last);
                    mismatch_cnt++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [15:0] fresh_keys[$];
        logic [15:0] drain_keys[$];
        logic [15:0] tmp;
        logic [15:0] miss_key;
        bit          seen[int];
        int          ph;
        int          n;
        int          j;
        int unsigned send_pcts[4];
        int unsigned stall_pcts[4];

        send_pcts  = '{0, 79, 0, 27};
        stall_pcts = '{0, 0, 79, 27};
        for (j = 0; j < POOL_SIZE; j++)
            key_pool[j] = 16'($urandom_range(1, 16'hFFFF));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, bad key, extremes, duplicates, deletes at both ends.
        op_queue.push_back(make_op(skt_pkg::ACT_LIST, 16'h0000));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, 16'hFFFF));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h0000));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'hFFFF));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h0001));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h8000));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h7FFF));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'hFFFF));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h0001));
        op_queue.push_back(make_op(skt_pkg::ACT_LIST, 16'h5555));
        op_queue.push_back(make_op(~skt_pkg::ACT_INSERT, 16'hAAAA));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, 16'h0000));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, 16'h1234));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, 16'h0001));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, 16'hFFFF));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, 16'h8000));
        op_queue.push_back(make_op(skt_pkg::ACT_LIST, 16'hFFFF));
        op_queue.push_back(make_op(~skt_pkg::ACT_INSERT, 16'h5555));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, 16'h7FFF));
        op_queue.push_back(make_op(skt_pkg::ACT_LIST, 16'h0000));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h00FF));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h0100));

        // Random phases, each under its own idling pattern.
        for (ph = 0; ph < 4; ph++) begin
            wait_idle();
            send_idle_pct = send_pcts[ph];
            stall_pct = stall_pcts[ph];
            for (j = 0; j < PHASE_OPS; j++)
                op_queue.push_back(random_op());
        end

        // Fill the table to capacity with fresh keys, then probe the full table.
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 79;
        for (j = 0; j < n_keys; j++) begin
            seen[keys_tbl[j]] = 1'b1;
            drain_keys.push_back(keys_tbl[j]);
        end
        while (drain_keys.size() < CAPACITY) begin
            tmp = 16'($urandom_range(1, 16'hFFFF));
            if (!seen.exists(tmp)) begin
                seen[tmp] = 1'b1;
                fresh_keys.push_back(tmp);
                drain_keys.push_back(tmp);
            end
        end
        do
            miss_key = 16'($urandom_range(1, 16'hFFFF));
        while (seen.exists(miss_key));
        foreach (fresh_keys[k])
            op_queue.push_back(make_op(skt_pkg::ACT_INSERT, fresh_keys[k]));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, miss_key));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT,
                                   drain_keys[$urandom_range(0, CAPACITY - 1)]));
        op_queue.push_back(make_op(skt_pkg::ACT_INSERT, 16'h0000));
        op_queue.push_back(make_op(skt_pkg::ACT_LIST, 16'h0000));

        // Drain in random order, listing now and then, back to an empty table.
        wait_idle();
        send_idle_pct = 79;
        stall_pct = 0;
        for (j = drain_keys.size() - 1; j > 0; j--) begin
            n = $urandom_range(0, j);
            tmp = drain_keys[j];
            drain_keys[j] = drain_keys[n];
            drain_keys[n] = tmp;
        end
        foreach (drain_keys[k]) begin
            op_queue.push_back(make_op(skt_pkg::ACT_DELETE, drain_keys[k]));
            if (k % 16 == 15) begin
                op_queue.push_back(make_op(skt_pkg::ACT_LIST, 16'h0000));
                op_queue.push_back(make_op(skt_pkg::ACT_DELETE, miss_key));
            end
        end
        op_queue.push_back(make_op(skt_pkg::ACT_LIST, 16'h0000));
        op_queue.push_back(make_op(skt_pkg::ACT_DELETE, miss_key));

        // Let any late or stray output show up before the verdict.
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0 && table_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/skt_pkg.sv
design/skt_cell.sv
design/sorted_key_table.sv
dv/tb_sorted_key_table.sv
